FILE: hdl/lfrd_pkg.sv
`timescale 1ns / 1ps
package lfrd_pkg;

	localparam int unsigned TIME_W     = 48;
	localparam int unsigned IN_TIME_W  = 32;
	localparam int unsigned USE_W      = 16;
	localparam int unsigned ROOM_OUT_W = 4;
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned S_DATA_W   = 2 * IN_TIME_W;
	localparam int unsigned M_DATA_W   = 2 * ROOM_OUT_W + 2 * TIME_W;

	localparam logic [CFG_W-1:0]  ROOM_COUNT_RST = CFG_W'(16);
	localparam logic [TIME_W-1:0] TIME_MAX       = '1;
	localparam logic [USE_W-1:0]  USE_MAX        = '1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_TALLY = 5'b01000,
		ST_DONE  = 5'b10000
	} lfrd_state_t;

endpackage

FILE: hdl/lfrd_ram.sv
`timescale 1ns / 1ps
module lfrd_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/lowest_free_room_dispatcher.sv
`timescale 1ns / 1ps
// lowest-free-room dispatcher
// input items (s_*) are meetings in start order: tdata holds start and end
// time, tlast marks the last meeting of a batch. each meeting goes to the
// lowest free room at its start, or else waits for the room that frees first
// (lowest index on ties). one result item (m_*) per meeting: room, begin and
// finish time, and on tlast the most used room of the batch.
// cfg_* writes the active room count; write it only while the block is idle.
// from acceptance to its result on m_*, a meeting takes one pass over the
// active rooms in the room stores, each read through its single read port;
// the last meeting of a batch adds a second pass to tally use counts.
// s_tready is high only between meetings, so a new meeting is taken only
// after the last one has been written and its result has moved on to the
// output register.
// the result sits in an output register, so the next meeting is taken while
// it waits; a stalled receiver holds the block only when the next result is
// ready to leave. reset clears all rooms, sets the room count to 16 and
// drops m_tvalid; room state also clears after each last meeting.
module lowest_free_room_dispatcher
	import lfrd_pkg::*;
#(
	parameter int unsigned MAX_ROOMS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // start_time, end_time
	input  logic                s_tlast,  // last_meeting
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // assigned_room, begin_time, finish_time, busiest_room
	output logic                m_tlast,  // batch_done
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data  // room_count
);

	localparam int unsigned IW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int unsigned CW = $clog2(MAX_ROOMS + 1);

	lfrd_state_t state_q;
	logic [CFG_W-1:0]     room_count_q;
	logic [CW-1:0]        rc_q;
	logic [CW-1:0]        cnt_q;
	logic                 vld_s1;
	logic [IW-1:0]        idx_s1;
	logic [MAX_ROOMS-1:0] valid_q;
	logic                 m_tvalid_q;

	logic [IN_TIME_W-1:0] start_q;
	logic [IN_TIME_W-1:0] dur_q;
	logic                 last_q;
	logic                 found_q;
	logic [IW-1:0]        fpick_q;
	logic [USE_W-1:0]     fuse_q;
	logic [TIME_W-1:0]    min_q;
	logic [IW-1:0]        mpick_q;
	logic [USE_W-1:0]     muse_q;
	logic [IW-1:0]        pick_q;
	logic [TIME_W-1:0]    begin_q;
	logic [TIME_W-1:0]    finish_q;
	logic [USE_W-1:0]     best_use_q;
	logic [IW-1:0]        best_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic                 m_tlast_q;

	logic [TIME_W-1:0] busy_rd, busy_v;
	logic [USE_W-1:0]  use_rd, use_v;
	logic              we;
	logic [IW-1:0]     pick;
	logic [TIME_W-1:0] begin_c, finish_c;
	logic [TIME_W:0]   sum_c;
	logic [USE_W-1:0]  use_c, use_inc;
	logic [CW-1:0]     rc_c;
	logic              accept, out_free, issue;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign issue     = (cnt_q != rc_q);

	always_comb begin
		if (room_count_q == '0) begin
			rc_c = CW'(1);
		end else if (32'(room_count_q) > MAX_ROOMS) begin
			rc_c = CW'(MAX_ROOMS);
		end else begin
			rc_c = CW'(room_count_q);
		end
	end

	// entries not written since the last clear read as zero
	assign busy_v = valid_q[idx_s1] ? busy_rd : '0;
	assign use_v  = valid_q[idx_s1] ? use_rd : '0;

	assign pick     = found_q ? fpick_q : mpick_q;
	assign begin_c  = found_q ? TIME_W'(start_q) : min_q;
	assign sum_c    = {1'b0, begin_c} + (TIME_W + 1)'(dur_q);
	assign finish_c = sum_c[TIME_W] ? TIME_MAX : sum_c[TIME_W-1:0];
	assign use_c    = found_q ? fuse_q : muse_q;
	assign use_inc  = (use_c == USE_MAX) ? use_c : use_c + USE_W'(1);
	assign we       = (state_q == ST_WRITE);

	lfrd_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ROOMS)) u_busy_ram (
		.clk   (clk),
		.we    (we),
		.waddr (pick),
		.wdata (finish_c),
		.raddr (cnt_q[IW-1:0]),
		.rdata (busy_rd)
	);

	lfrd_ram #(.WIDTH(USE_W), .DEPTH(MAX_ROOMS)) u_use_ram (
		.clk   (clk),
		.we    (we),
		.waddr (pick),
		.wdata (use_inc),
		.raddr (cnt_q[IW-1:0]),
		.rdata (use_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			room_count_q <= ROOM_COUNT_RST;
			rc_q         <= '0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			valid_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				room_count_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rc_q    <= rc_c;
						cnt_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN, ST_TALLY: begin
					vld_s1 <= issue;
					if (issue) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (state_q == ST_SCAN) begin
						state_q <= ST_WRITE;
					end else begin
						valid_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					valid_q[pick] <= 1'b1;
					cnt_q         <= '0;
					vld_s1        <= 1'b0;
					state_q       <= last_q ? ST_TALLY : ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					start_q <= s_tdata[IN_TIME_W-1:0];
					dur_q   <= (s_tdata[S_DATA_W-1:IN_TIME_W] > s_tdata[IN_TIME_W-1:0])
						? s_tdata[S_DATA_W-1:IN_TIME_W] - s_tdata[IN_TIME_W-1:0] : '0;
					last_q  <= s_tlast;
					found_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (vld_s1) begin
					if (!found_q && busy_v <= TIME_W'(start_q)) begin
						found_q <= 1'b1;
						fpick_q <= idx_s1;
						fuse_q  <= use_v;
					end
					if (idx_s1 == '0 || busy_v < min_q) begin
						min_q   <= busy_v;
						mpick_q <= idx_s1;
						muse_q  <= use_v;
					end
				end
			end
			ST_WRITE: begin
				pick_q   <= pick;
				begin_q  <= begin_c;
				finish_q <= finish_c;
				best_q   <= '0;
			end
			ST_TALLY: begin
				if (vld_s1 && (idx_s1 == '0 || use_v > best_use_q)) begin
					best_use_q <= use_v;
					best_q     <= idx_s1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {ROOM_OUT_W'(best_q), finish_q, begin_q, ROOM_OUT_W'(pick_q)};
					m_tlast_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: hdl/lfrd_checker.sv
`timescale 1ns / 1ps
module lfrd_checker
	import lfrd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	localparam int unsigned BEG_LO = ROOM_OUT_W;
	localparam int unsigned FIN_LO = ROOM_OUT_W + TIME_W;
	localparam int unsigned BST_LO = ROOM_OUT_W + 2 * TIME_W;

	// one meeting in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	a_finish_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[FIN_LO +: TIME_W] >= m_tdata[BEG_LO +: TIME_W])
		else $error("finish before begin");

	a_busiest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[BST_LO +: ROOM_OUT_W] == '0)
		else $error("busiest room set outside batch end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind lowest_free_room_dispatcher lfrd_checker u_lfrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
